[hw/rtl/fufe_pkg.sv]
// shared types, constants and helper functions of the form field extractor
`default_nettype none

package fufe_pkg;

  // key characters the matcher can hold
  localparam int MAX_KEY_CHARS = 8;
  // default output buffer size bound
  localparam int MAX_CAPACITY_DEF = 1024;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int KEY_LEN_W  = 4;
  localparam int CAP_CFG_W  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_BYTES    = 2'd0,
    CFG_KEY_LENGTH   = 2'd1,
    CFG_OUT_CAPACITY = 2'd2
  } cfg_index_e;

  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RST = 4'd4;
  localparam logic [CAP_CFG_W-1:0]  OUT_CAP_RST = 11'd64;

  // result queue
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int MAX_RESULTS = 3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  typedef enum logic [4:0] {
    PH_MATCH = 5'b00001,
    PH_SKIP  = 5'b00010,
    PH_VALUE = 5'b00100,
    PH_ESC1  = 5'b01000,
    PH_ESC2  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_BAD_ESCAPE = 2'd2
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    status_e    status;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h = '0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - (CH_LA - 8'd10);
      h.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - (CH_UA - 8'd10);
      h.ok = 1'b1;
    end
    h.val = t[3:0];
    return h;
  endfunction

  function automatic item_t data_item(logic [7:0] d);
    item_t it;
    it.data   = d;
    it.kind   = KIND_DATA;
    it.status = ST_FOUND;
    return it;
  endfunction

  function automatic item_t status_item(status_e st);
    item_t it;
    it.data   = CH_NUL;
    it.kind   = KIND_STATUS;
    it.status = st;
    return it;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/form_urlencoded_field_extractor.sv]
// form-urlencoded field extractor: key match, percent decode, result queue
//
// Usage: body bytes enter on the in_valid_i/in_ready_o channel, one beat per
// byte; a zero byte ends the body and returns the parser to field start.
// Results leave on the out_valid_o/out_ready_i channel: data beats carry a
// decoded value byte (kind 0), and each body closes with one status beat
// (kind 1, last 1) giving found, not found or bad escape.
// A byte accepted is held in the input register, parsed from there into the
// result queue, and offered to the receiver from the queue head.
// Throughput: one byte per cycle. A byte gives at most three results; they
// go into a four-entry result queue, and a byte is parsed only when the
// queue has room for three, so a byte that gives one result each cycle
// streams at full rate while the receiver takes one beat per cycle.
// When the receiver stalls, the queue fills and in_ready_o falls after the
// input register is also held; nothing is dropped.
// Reset clears the parser, the queue and the input register; key_bytes
// resets to zero, key_length to 4 and out_capacity to 64. Configuration
// is written through cfg_we_i/cfg_index_i/cfg_data_i while the block idles.
`default_nettype none

module form_urlencoded_field_extractor
  import fufe_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            in_byte_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            out_byte_o,
  output      logic                  kind_o,
  output      logic [1:0]            status_o,
  output      logic                  last_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CntW = $clog2(MAX_CAPACITY);
  localparam int CapW = (CAP_CFG_W > CntW + 1) ? CAP_CFG_W : CntW + 1;

  // configuration
  logic [CFG_DATA_W-1:0] key_bytes_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [CAP_CFG_W-1:0]  out_cap_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // parser state
  phase_e             phase_q, phase_d;
  logic [KEY_LEN_W-1:0] key_pos_q, key_pos_d;
  logic [7:0]         esc_digit_q, esc_digit_d;
  logic [CntW-1:0]    emitted_q, emitted_d;
  logic               sent_q, sent_d;

  // result queue
  item_t                 fifo_q [FIFO_DEPTH];
  item_t                 fifo_d [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] rd_ptr_q, wr_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic [FIFO_PTR_W-1:0] push_cnt;

  logic pop;
  logic room;
  logic proc;
  logic in_accept;

  logic [KEY_LEN_W-1:0] klen;
  logic [7:0]           key_char;
  logic [CapW-1:0]      cap_eff;
  logic [CntW-1:0]      lim;
  hex_t                 hex_hi, hex_lo;
  item_t                head;

  // ---------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= '0;
      key_len_q   <= KEY_LEN_RST;
      out_cap_q   <= OUT_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_BYTES:    key_bytes_q <= cfg_data_i;
        CFG_KEY_LENGTH:   key_len_q   <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_OUT_CAPACITY: out_cap_q   <= cfg_data_i[CAP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective key length and value byte limit
  always_comb begin
    klen = (key_len_q > KEY_LEN_W'(MAX_KEY_CHARS)) ? KEY_LEN_W'(MAX_KEY_CHARS) : key_len_q;
    cap_eff = CapW'(out_cap_q);
    if (cap_eff == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_eff > CapW'(MAX_CAPACITY)) begin
      cap_eff = CapW'(MAX_CAPACITY);
    end
    lim = CntW'(cap_eff - CapW'(1));
  end

  assign key_char = key_bytes_q[8*key_pos_q[2:0] +: 8];
  assign hex_hi   = hex_decode(esc_digit_q);
  assign hex_lo   = hex_decode(in_byte_q);

  // ---------------------------------------------------------------------
  // handshake and queue room
  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign out_byte_o  = head.data;
  assign kind_o      = head.kind;
  assign status_o    = head.status;
  assign last_o      = head.kind;
  assign pop         = out_valid_o && out_ready_i;

  // parse only with room for a full burst of results after this cycle's pop
  assign room = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS)) ||
                (pop && (count_q == FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS + 1)));
  assign proc       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || proc;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  // ---------------------------------------------------------------------
  // parser step
  always_comb begin
    logic       da_en;
    logic       db_en;
    logic       st_en;
    logic [7:0] da;
    logic [7:0] db;
    status_e    st_val;
    logic [FIFO_PTR_W-1:0] slot;

    phase_d     = phase_q;
    key_pos_d   = key_pos_q;
    esc_digit_d = esc_digit_q;
    emitted_d   = emitted_q;
    sent_d      = sent_q;
    fifo_d      = fifo_q;
    push_cnt    = '0;
    da_en       = 1'b0;
    db_en       = 1'b0;
    st_en       = 1'b0;
    da          = in_byte_q;
    db          = esc_digit_q;
    st_val      = ST_FOUND;
    slot        = wr_ptr_q;

    if (proc && !sent_q) begin
      unique case (phase_q)
        PH_MATCH: begin
          if (in_byte_q == CH_NUL) begin
            st_en  = 1'b1;
            st_val = ST_NOT_FOUND;
          end else if (key_pos_q < klen) begin
            priority if (in_byte_q == CH_AMP) begin
              key_pos_d = '0;
            end else if (in_byte_q == key_char) begin
              key_pos_d = key_pos_q + KEY_LEN_W'(1);
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (in_byte_q == CH_EQ) begin
            phase_d   = PH_VALUE;
            emitted_d = '0;
            st_en     = (lim == '0);
          end else if (in_byte_q == CH_AMP) begin
            key_pos_d = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_byte_q == CH_NUL) begin
            st_en  = 1'b1;
            st_val = ST_NOT_FOUND;
          end else if (in_byte_q == CH_AMP) begin
            phase_d   = PH_MATCH;
            key_pos_d = '0;
          end
        end
        PH_VALUE: begin
          priority if (in_byte_q == CH_NUL || in_byte_q == CH_AMP) begin
            st_en = 1'b1;
          end else if (in_byte_q == CH_PLUS) begin
            da_en = 1'b1;
            da    = CH_SPACE;
          end else if (in_byte_q == CH_PCT) begin
            phase_d = PH_ESC1;
          end else begin
            da_en = 1'b1;
          end
        end
        PH_ESC1: begin
          if (in_byte_q == CH_NUL) begin
            // lone percent at end of body is copied
            da_en = 1'b1;
            da    = CH_PCT;
            st_en = 1'b1;
          end else begin
            esc_digit_d = in_byte_q;
            phase_d     = PH_ESC2;
          end
        end
        PH_ESC2: begin
          if (in_byte_q == CH_NUL) begin
            // percent plus one byte at end of body: copy, then decode the byte
            da_en = 1'b1;
            da    = CH_PCT;
            db_en = (esc_digit_q != CH_AMP);
            db    = (esc_digit_q == CH_PLUS) ? CH_SPACE : esc_digit_q;
            st_en = 1'b1;
          end else begin
            esc_digit_d = '0;
            phase_d     = PH_VALUE;
            if (!hex_hi.ok || !hex_lo.ok) begin
              st_en  = 1'b1;
              st_val = ST_BAD_ESCAPE;
            end else begin
              da_en = 1'b1;
              da    = {hex_hi.val, hex_lo.val};
            end
          end
        end
        default: ;
      endcase

      // emit data beats, closing with found once the limit is hit, then any status beat
      if (da_en) begin
        slot         = wr_ptr_q + push_cnt;
        fifo_d[slot] = data_item(da);
        push_cnt     = push_cnt + FIFO_PTR_W'(1);
        emitted_d    = emitted_d + CntW'(1);
        if (emitted_d >= lim) begin
          slot         = wr_ptr_q + push_cnt;
          fifo_d[slot] = status_item(ST_FOUND);
          push_cnt     = push_cnt + FIFO_PTR_W'(1);
          sent_d       = 1'b1;
        end
      end
      if (db_en && !sent_d) begin
        slot         = wr_ptr_q + push_cnt;
        fifo_d[slot] = data_item(db);
        push_cnt     = push_cnt + FIFO_PTR_W'(1);
        emitted_d    = emitted_d + CntW'(1);
        if (emitted_d >= lim) begin
          slot         = wr_ptr_q + push_cnt;
          fifo_d[slot] = status_item(ST_FOUND);
          push_cnt     = push_cnt + FIFO_PTR_W'(1);
          sent_d       = 1'b1;
        end
      end
      if (st_en && !sent_d) begin
        slot         = wr_ptr_q + push_cnt;
        fifo_d[slot] = status_item(st_val);
        push_cnt     = push_cnt + FIFO_PTR_W'(1);
        sent_d       = 1'b1;
      end
    end

    // end of body restarts the parser
    if (proc && in_byte_q == CH_NUL) begin
      phase_d     = PH_MATCH;
      key_pos_d   = '0;
      esc_digit_d = '0;
      emitted_d   = '0;
      sent_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MATCH;
      key_pos_q   <= '0;
      esc_digit_q <= '0;
      emitted_q   <= '0;
      sent_q      <= 1'b0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      key_pos_q   <= key_pos_d;
      esc_digit_q <= esc_digit_d;
      emitted_q   <= emitted_d;
      sent_q      <= sent_d;
      wr_ptr_q    <= wr_ptr_q + push_cnt;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  // ---------------------------------------------------------------------
  // assertions
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_body_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !sent_q && in_byte_q == CH_NUL) |-> (push_cnt != '0))
    else $error("end of body without a status beat");

  a_body_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_byte_q == CH_NUL) |=>
      (phase_q == PH_MATCH && !sent_q && key_pos_q == '0 && emitted_q == '0))
    else $error("parser not restarted after end of body");

  a_amp_ends_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !sent_q && phase_q == PH_VALUE && in_byte_q == CH_AMP) |=> sent_q)
    else $error("ampersand did not close the value");

endmodule

`default_nettype wire

[tb/tb_form_urlencoded_field_extractor.sv]
// testbench for the form-urlencoded field extractor with its own decode predictor
`timescale 1ns / 100ps

module tb_form_urlencoded_field_extractor;
  import fufe_pkg::*;

  localparam int RANDOM_BYTES   = 60;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    status_e    status;
    logic       last;
  } beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            in_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            out_byte_o;
  logic                  kind_o;
  logic [1:0]            status_o;
  logic                  last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor copy of the registers and the parser
  logic [63:0] key_reg;
  logic [3:0]  key_len_reg;
  logic [10:0] cap_reg;
  phase_e      ph;
  int          key_pos;
  int          emitted;
  logic [7:0]  esc_hi;
  bit          closed;

  beat_t       decoded_q[$];
  logic [7:0]  body_q[$];

  bit steady       = 1'b0;
  bit hold_results = 1'b0;
  int mismatches   = 0;
  int bytes_sent   = 0;
  int bodies_sent  = 0;
  int data_beats   = 0;
  int found_beats  = 0;
  int missing_beats = 0;
  int bad_beats    = 0;
  int quiet_cycles = 0;

  form_urlencoded_field_extractor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 7);
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int key_chars();
    return (key_len_reg > MAX_KEY_CHARS) ? MAX_KEY_CHARS : int'(key_len_reg);
  endfunction

  function automatic int value_limit();
    int c;
    c = int'(cap_reg);
    if (c == 0) c = 1;
    if (c > MAX_CAPACITY_DEF) c = MAX_CAPACITY_DEF;
    return c - 1;
  endfunction

  function automatic void restart_body();
    ph      = PH_MATCH;
    key_pos = 0;
    esc_hi  = CH_NUL;
    emitted = 0;
    closed  = 1'b0;
  endfunction

  function automatic void push_status(status_e st);
    decoded_q.push_back('{data: CH_NUL, kind: KIND_STATUS, status: st, last: 1'b1});
    closed = 1'b1;
  endfunction

  function automatic void push_data(logic [7:0] d);
    decoded_q.push_back('{data: d, kind: KIND_DATA, status: ST_FOUND, last: 1'b0});
    emitted++;
    if (emitted >= value_limit()) push_status(ST_FOUND);
  endfunction

  function automatic void parse_body_byte(logic [7:0] b);
    int klen;
    int hi;
    int lo;
    klen = key_chars();
    // after the status beat everything up to the zero byte is dropped
    if (closed) begin
      if (b == CH_NUL) restart_body();
      return;
    end
    case (ph)
      PH_MATCH: begin
        if (b == CH_NUL) begin
          push_status(ST_NOT_FOUND);
        end else if (key_pos < klen) begin
          if (b == CH_AMP) key_pos = 0;
          else if (b == key_reg[8*key_pos +: 8]) key_pos++;
          else ph = PH_SKIP;
        end else if (b == CH_EQ) begin
          ph      = PH_VALUE;
          emitted = 0;
          if (value_limit() == 0) push_status(ST_FOUND);
        end else if (b == CH_AMP) begin
          key_pos = 0;
        end else begin
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CH_NUL) begin
          push_status(ST_NOT_FOUND);
        end else if (b == CH_AMP) begin
          ph      = PH_MATCH;
          key_pos = 0;
        end
      end
      PH_VALUE: begin
        if (b == CH_NUL || b == CH_AMP) push_status(ST_FOUND);
        else if (b == CH_PLUS) push_data(CH_SPACE);
        else if (b == CH_PCT) ph = PH_ESC1;
        else push_data(b);
      end
      PH_ESC1: begin
        if (b == CH_NUL) begin
          push_data(CH_PCT);
          if (!closed) push_status(ST_FOUND);
        end else begin
          esc_hi = b;
          ph     = PH_ESC2;
        end
      end
      default: begin
        if (b == CH_NUL) begin
          // escape cut short by end of body: copy it as plain text
          push_data(CH_PCT);
          if (!closed) begin
            if (esc_hi == CH_PLUS) push_data(CH_SPACE);
            else if (esc_hi != CH_AMP) push_data(esc_hi);
          end
          if (!closed) push_status(ST_FOUND);
        end else begin
          hi     = nibble_of(esc_hi);
          lo     = nibble_of(b);
          esc_hi = CH_NUL;
          ph     = PH_VALUE;
          if (hi < 0 || lo < 0) push_status(ST_BAD_ESCAPE);
          else push_data(8'(hi * 16 + lo));
        end
      end
    endcase
    if (b == CH_NUL) restart_body();
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_AMP || b == CH_PCT || b == CH_PLUS);
    return b;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (take_break()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i);
      while (take_break());
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_body_byte(b);
    bytes_sent++;
    if (b == CH_NUL) bodies_sent++;
  endtask

  task automatic send_body_q();
    while (body_q.size() != 0) send_byte(body_q.pop_front());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    body_q.push_back(CH_NUL);
    send_body_q();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all three registers; upper data bits above key length and capacity are junk
  task automatic set_config(input logic [63:0] kb, input logic [3:0] kl,
                            input logic [10:0] cap);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_KEY_BYTES;
    cfg_data_i  <= kb;
    @(posedge clk_i);
    cfg_index_i <= CFG_KEY_LENGTH;
    cfg_data_i  <= {junk[63:4], kl};
    @(posedge clk_i);
    cfg_index_i <= CFG_OUT_CAPACITY;
    cfg_data_i  <= {junk[63:11], cap};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_reg     = kb;
    key_len_reg = kl;
    cap_reg     = cap;
  endtask

  task automatic send_random_body();
    int nfields;
    int natoms;
    int cut;
    int r;
    int i;
    if ($urandom_range(0, 99) < 15) begin
      // noise body
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      nfields = $urandom_range(1, 3);
      for (int f = 0; f < nfields; f++) begin
        if (f != 0) body_q.push_back(CH_AMP);
        r   = $urandom_range(0, 9);
        cut = (r < 5) ? key_chars() : $urandom_range(0, key_chars());
        for (i = 0; i < cut; i++) body_q.push_back(key_reg[8*i +: 8]);
        if (r >= 5) repeat ($urandom_range(0, 2)) body_q.push_back(rand_plain());
        if ($urandom_range(0, 9) != 0) body_q.push_back(CH_EQ);
        natoms = $urandom_range(0, 6);
        repeat (natoms) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            body_q.push_back(rand_plain());
          end else if (r < 6) begin
            body_q.push_back(CH_PLUS);
          end else if (r < 9) begin
            body_q.push_back(CH_PCT);
            body_q.push_back(rand_hex_digit());
            body_q.push_back(rand_hex_digit());
          end else begin
            body_q.push_back(CH_PCT);
            body_q.push_back(8'($urandom_range(1, 255)));
            body_q.push_back(8'($urandom_range(1, 255)));
          end
        end
      end
      // sometimes end on a truncated escape
      r = $urandom_range(0, 9);
      if (r == 0) begin
        body_q.push_back(CH_PCT);
      end else if (r == 1) begin
        body_q.push_back(CH_PCT);
        case ($urandom_range(0, 2))
          0:       body_q.push_back(CH_PLUS);
          1:       body_q.push_back(CH_AMP);
          default: body_q.push_back(rand_plain());
        endcase
      end
    end
    body_q.push_back(CH_NUL);
    send_body_q();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_config();
    send_text("x");
    wait_idle();
  endtask

  task automatic test_decode_and_capacity();
    set_config(64'("k"), 4'd1, 11'd3);
    // '&' while matching, lowercase escape, plus, capacity hit, trailing byte dropped
    send_text("&k=%4a+Q");
    wait_idle();
  endtask

  task automatic test_empty_key_zero_capacity();
    set_config('1, 4'd0, 11'd0);
    send_text("=");
    wait_idle();
  endtask

  task automatic test_escape_edges();
    set_config(64'("k"), 4'd1, 11'd64);
    send_text("k=%G1");
    send_text("k=%C3%+");
    send_text("k=%");
    wait_idle();
  endtask

  task automatic test_full_rate();
    steady = 1'b1;
    set_config(64'({"d", "i"}), 4'd2, 11'd64);
    repeat (2) begin
      body_q.push_back("i");
      body_q.push_back("d");
      body_q.push_back(CH_EQ);
      repeat (20) body_q.push_back(rand_plain());
      body_q.push_back(CH_AMP);
      body_q.push_back(CH_NUL);
      send_body_q();
    end
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config('1, 4'd15, 11'd2047);
    hold_results = 1'b1;
    // key length saturates to eight, so the full key precedes the value
    repeat (MAX_KEY_CHARS) body_q.push_back(8'hff);
    body_q.push_back(CH_EQ);
    repeat (24) body_q.push_back(rand_plain());
    body_q.push_back(CH_NUL);
    send_body_q();
    wait_idle();
  endtask

  task automatic test_random_bodies();
    int          first;
    int          r;
    logic [63:0] kb;
    logic [3:0]  kl;
    logic [10:0] cap;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      wait_idle();
      kb = {$urandom, $urandom};
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 9) < 8) kb[8*k +: 8] = 8'($urandom_range('h30, 'h7a));
      end
      r  = $urandom_range(0, 9);
      kl = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      case ($urandom_range(0, 19))
        0:       cap = 11'd0;
        1:       cap = 11'd1;
        2:       cap = 11'd1024;
        3:       cap = 11'd2047;
        4, 5:    cap = 11'd64;
        default: cap = 11'($urandom_range(2, 10));
      endcase
      set_config(kb, kl, cap);
      repeat ($urandom_range(2, 5)) send_random_body();
    end
    wait_idle();
  endtask

  // ------------------------------------------------------------ processes

  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= !take_break();
    end
  end

  always @(posedge clk_i) begin : check_results
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected beat: out_byte %02h kind %0d status %0d last %0d",
               out_byte_o, kind_o, status_o, last_o);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte_o);
          mismatches++;
        end
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
        if (want.kind == KIND_DATA) data_beats++;
        else if (want.status == ST_FOUND) found_beats++;
        else if (want.status == ST_NOT_FOUND) missing_beats++;
        else bad_beats++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no beat", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = CH_NUL;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_KEY_BYTES;
    cfg_data_i  = '0;
    key_reg     = '0;
    key_len_reg = KEY_LEN_RST;
    cap_reg     = OUT_CAP_RST;
    restart_body();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_decode_and_capacity();
    test_empty_key_zero_capacity();
    test_escape_edges();
    test_full_rate();
    test_backpressure();
    test_random_bodies();
    wait_idle();

    $display("sent %0d body bytes in %0d bodies over key lengths 0..15 and capacities 0..2047",
             bytes_sent, bodies_sent);
    $display("checked %0d data beats and %0d/%0d/%0d found/not-found/bad-escape status beats",
             data_beats, found_beats, missing_beats, bad_beats);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fufe_pkg.sv
hw/rtl/form_urlencoded_field_extractor.sv
tb/tb_form_urlencoded_field_extractor.sv
